FILE: rtl/tdldc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdldc_pkg;

	localparam int TABLE_ENTRIES_DEF = 8;

	localparam int IN_DATA_W  = 56;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [2:0] FN_WRITE_DATA   = 3'd0;
	localparam logic [2:0] FN_WRITE_STATUS = 3'd1;
	localparam logic [2:0] FN_SET_DIODES   = 3'd2;
	localparam logic [2:0] FN_CLR_DIODES   = 3'd3;
	localparam logic [2:0] FN_OFF          = 3'd4;
	localparam logic [2:0] FN_ON           = 3'd5;
	localparam logic [2:0] FN_TICK         = 3'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_COMMON_CATHODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLANK_PATTERN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DOT_MASK       = 2'd2;

	localparam int ST_FOCUS   = 15;
	localparam int ST_DEC     = 14;
	localparam int ST_HEX     = 13;
	localparam int ST_AUTOOFF = 12;
	localparam int ST_DOT0    = 11;
	localparam int ST_DOT1    = 10;
	localparam int ST_BLANK0  = 9;
	localparam int ST_BLANK1  = 8;
	localparam int ST_SDIODE  = 5;
	localparam int ST_RDIODE  = 4;

	localparam logic [15:0] ST_UPPER_MASK = 16'hFFF0;
	localparam logic [15:0] ST_SELECT_MASK = 16'b0000000000001111;

	localparam logic [6:0] DEC_MAX   = 7'd99;
	localparam logic [6:0] DEC_RADIX = 7'd10;

	localparam logic [7:0] RST_BLANK_PATTERN = 8'hFF;
	localparam logic [7:0] RST_DOT_MASK      = 8'h7F;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_FORM
	} state_t;

	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'h0: s = 8'b11000000;
			4'h1: s = 8'b11111001;
			4'h2: s = 8'b10100100;
			4'h3: s = 8'b10110000;
			4'h4: s = 8'b10011001;
			4'h5: s = 8'b10010010;
			4'h6: s = 8'b10000010;
			4'h7: s = 8'b11111000;
			4'h8: s = 8'b10000000;
			4'h9: s = 8'b10010000;
			4'hA: s = 8'h88;
			4'hB: s = 8'h83;
			4'hC: s = 8'hC6;
			4'hD: s = 8'hA1;
			4'hE: s = 8'h86;
			4'hF: s = 8'h8E;
			default: s = 8'hFF;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/two_digit_led_display_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-digit multiplexed seven-segment display driver with indicator diodes.
// Input beats (s_axis_*): tuser carries the function code, tdata the
// entry, data bytes, status value/mask and diode bits. Table writes, diode
// set/clear and off/on take effect in the accept cycle and give no output.
// A refresh tick gives one output beat (m_axis_*): segment byte and diode
// drive in tdata, the digit select in tuser.
// A tick walks the scan, divide and form steps. The scan reads one table
// entry per cycle until it meets an entry with the focus bit or the last
// entry; the divide step does one subtract-by-ten step per cycle through the
// single compare/subtract unit for decimal entries and passes hex/raw
// entries straight on; s_axis_tready comes back with output valid.
// s_axis_tready is high only while the sequencer is idle; other beats
// leave it idle. The output beat sits in a register: if the receiver
// stalls, a finished beat holds and the block keeps taking non-tick beats;
// a following tick waits in its final step until the register is free.
// Reset (arst_n low) clears the table, diodes, off flag, digit phase and
// config registers (common anode, blank pattern FF, dot mask 7F).
// Config writes (cfg_we) are taken any cycle and should come while idle.
module two_digit_led_display_controller_core #(
	parameter int TABLE_ENTRIES = tdldc_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// entry[2:0], data_high[10:3], data_low[18:11], status_value[34:19],
	// status_mask[50:35], diode_bits[54:51], zero pad
	input  wire logic [tdldc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// func[2:0]
	input  wire logic [tdldc_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// segments[7:0], diode_drive[11:8], zero pad
	output logic [tdldc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// digit_select[0]
	output logic                                  m_axis_tuser,
	input  wire logic                             cfg_we,
	input  wire logic [tdldc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tdldc_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int AW = (IDX_W > 3) ? IDX_W : 3;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

	tdldc_pkg::state_t state_q, state_d;

	logic [31:0]      table_q [TABLE_ENTRIES];
	logic [IDX_W-1:0] idx_q;
	logic [31:0]      word_q;
	logic [6:0]       rem_q;
	logic [3:0]       tens_q;
	logic             mux_phase_q;
	logic             off_q;
	logic [3:0]       diodes_q;
	logic             cc_q;
	logic [7:0]       blank_q;
	logic [7:0]       dotm_q;
	logic             m_tvalid_q;
	logic [tdldc_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic             m_tuser_q;

	// input fields
	logic [2:0]  in_func;
	logic [2:0]  in_entry;
	logic [7:0]  in_dhi;
	logic [7:0]  in_dlo;
	logic [15:0] in_sval;
	logic [15:0] in_smsk;
	logic [3:0]  in_dbits;

	assign in_func  = s_axis_tuser;
	assign in_entry = s_axis_tdata[2:0];
	assign in_dhi   = s_axis_tdata[10:3];
	assign in_dlo   = s_axis_tdata[18:11];
	assign in_sval  = s_axis_tdata[34:19];
	assign in_smsk  = s_axis_tdata[50:35];
	assign in_dbits = s_axis_tdata[54:51];

	logic             in_beat;
	logic [AW-1:0]    wr_addr;
	logic             wr_ok;
	logic [IDX_W-1:0] rd_addr;
	logic [31:0]      rd_word;
	logic [15:0]      st_new;
	logic [15:0]      st_up;

	assign in_beat = s_axis_tvalid && s_axis_tready;
	assign wr_addr = AW'(in_entry);
	assign wr_ok   = 32'(wr_addr) < 32'(TABLE_ENTRIES);
	assign rd_addr = (state_q == tdldc_pkg::ST_IDLE) ? wr_addr[IDX_W-1:0] : idx_q;
	assign rd_word = table_q[rd_addr];

	always_comb begin
		st_up  = (rd_word[15:0] & ~(in_smsk & tdldc_pkg::ST_UPPER_MASK))
			| (in_sval & in_smsk & tdldc_pkg::ST_UPPER_MASK);
		st_new = st_up;
		if ((in_smsk & tdldc_pkg::ST_SELECT_MASK) != 16'd0
			&& (st_up[tdldc_pkg::ST_SDIODE] || st_up[tdldc_pkg::ST_RDIODE])
			&& (in_sval & tdldc_pkg::ST_SELECT_MASK) != 16'd0) begin
			st_new = (st_up & ~tdldc_pkg::ST_SELECT_MASK)
				| (in_sval & tdldc_pkg::ST_SELECT_MASK);
		end
	end

	// control decode
	logic        scan_hit;
	logic        dec_mode;
	logic        ge_radix;
	logic        div_done;
	logic        out_free;

	assign dec_mode = !word_q[tdldc_pkg::ST_HEX] && word_q[tdldc_pkg::ST_DEC];
	assign ge_radix = rem_q >= tdldc_pkg::DEC_RADIX;

	always_comb begin
		s_axis_tready = (state_q == tdldc_pkg::ST_IDLE);
		scan_hit      = (idx_q == LAST) || rd_word[tdldc_pkg::ST_FOCUS];
		div_done      = !dec_mode || !ge_radix;
		out_free      = !m_tvalid_q || m_axis_tready;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tdldc_pkg::ST_IDLE: begin
				if (in_beat && in_func == tdldc_pkg::FN_TICK)
					state_d = tdldc_pkg::ST_SCAN;
			end
			tdldc_pkg::ST_SCAN: begin
				if (scan_hit)
					state_d = tdldc_pkg::ST_DIV;
			end
			tdldc_pkg::ST_DIV: begin
				if (div_done)
					state_d = tdldc_pkg::ST_FORM;
			end
			tdldc_pkg::ST_FORM: begin
				if (out_free)
					state_d = tdldc_pkg::ST_IDLE;
			end
			default: state_d = tdldc_pkg::ST_IDLE;
		endcase
	end

	// digit formatting and diode drive
	logic [15:0] st;
	logic [7:0]  v;
	logic [7:0]  d1;
	logic [7:0]  d0;
	logic [3:0]  lit;
	logic [3:0]  sel;
	logic        phase_n;
	logic [7:0]  seg;
	logic [3:0]  drive;

	always_comb begin
		st  = word_q[15:0];
		v   = word_q[23:16];
		sel = st[3:0];
		if (st[tdldc_pkg::ST_HEX]) begin
			d1 = tdldc_pkg::seg_code(v[7:4]);
			d0 = tdldc_pkg::seg_code(v[3:0]);
		end else if (st[tdldc_pkg::ST_DEC]) begin
			d1 = tdldc_pkg::seg_code(tens_q);
			d0 = tdldc_pkg::seg_code(rem_q[3:0]);
		end else begin
			d1 = word_q[31:24];
			d0 = v;
		end
		if (st[tdldc_pkg::ST_AUTOOFF] && d1 == tdldc_pkg::seg_code(4'h0))
			d1 = blank_q;
		if (st[tdldc_pkg::ST_DOT0])
			d0 = d0 & dotm_q;
		if (st[tdldc_pkg::ST_DOT1])
			d1 = d1 & dotm_q;
		if (st[tdldc_pkg::ST_BLANK0] || off_q)
			d0 = blank_q;
		if (st[tdldc_pkg::ST_BLANK1] || off_q)
			d1 = blank_q;

		if (off_q) begin
			lit = 4'd0;
		end else if (sel != 4'd0 && (st[tdldc_pkg::ST_SDIODE] || st[tdldc_pkg::ST_RDIODE])) begin
			lit = st[tdldc_pkg::ST_SDIODE] ? (diodes_q | sel) : (diodes_q & ~sel);
		end else begin
			lit = diodes_q;
		end

		phase_n = !mux_phase_q;
		seg     = phase_n ? d0 : d1;
		drive   = cc_q ? lit : ~lit;
		if (cc_q)
			seg = ~seg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tdldc_pkg::ST_IDLE;
			idx_q       <= '0;
			mux_phase_q <= 1'b0;
			off_q       <= 1'b0;
			diodes_q    <= 4'd0;
			cc_q        <= 1'b0;
			blank_q     <= tdldc_pkg::RST_BLANK_PATTERN;
			dotm_q      <= tdldc_pkg::RST_DOT_MASK;
			m_tvalid_q  <= 1'b0;
			for (int i = 0; i < TABLE_ENTRIES; i++)
				table_q[i] <= 32'd0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					tdldc_pkg::CFG_COMMON_CATHODE: cc_q    <= cfg_data[0];
					tdldc_pkg::CFG_BLANK_PATTERN:  blank_q <= cfg_data;
					tdldc_pkg::CFG_DOT_MASK:       dotm_q  <= cfg_data;
					default: ;
				endcase
			end

			if (in_beat) begin
				case (in_func)
					tdldc_pkg::FN_WRITE_DATA: begin
						if (wr_ok)
							table_q[wr_addr[IDX_W-1:0]] <= {in_dhi, in_dlo, rd_word[15:0]};
					end
					tdldc_pkg::FN_WRITE_STATUS: begin
						if (wr_ok)
							table_q[wr_addr[IDX_W-1:0]] <= {rd_word[31:16], st_new};
					end
					tdldc_pkg::FN_SET_DIODES: diodes_q <= diodes_q | in_dbits;
					tdldc_pkg::FN_CLR_DIODES: diodes_q <= diodes_q & ~in_dbits;
					tdldc_pkg::FN_OFF:        off_q    <= 1'b1;
					tdldc_pkg::FN_ON:         off_q    <= 1'b0;
					tdldc_pkg::FN_TICK:       idx_q    <= '0;
					default: ;
				endcase
			end

			if (state_q == tdldc_pkg::ST_SCAN && !scan_hit)
				idx_q <= idx_q + 1'b1;

			if (state_q == tdldc_pkg::ST_FORM && out_free) begin
				m_tvalid_q  <= 1'b1;
				mux_phase_q <= phase_n;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == tdldc_pkg::ST_SCAN && scan_hit) begin
			word_q <= rd_word;
			tens_q <= 4'd0;
			rem_q  <= (rd_word[23:16] > 8'(tdldc_pkg::DEC_MAX)) ? tdldc_pkg::DEC_MAX
				: rd_word[22:16];
		end
		if (state_q == tdldc_pkg::ST_DIV && dec_mode && ge_radix) begin
			rem_q  <= rem_q - tdldc_pkg::DEC_RADIX;
			tens_q <= tens_q + 4'd1;
		end
		if (state_q == tdldc_pkg::ST_FORM && out_free) begin
			m_tdata_q <= {4'd0, drive, seg};
			m_tuser_q <= phase_n;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

`ifndef SYNTH
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && in_func == tdldc_pkg::FN_TICK) |=> !s_axis_tready)
		else $error("tick beat did not start the sequencer");

	a_phase_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == mux_phase_q))
		else $error("held digit select differs from mux phase");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tdldc_pkg::ST_DIV) |-> (rem_q <= tdldc_pkg::DEC_MAX))
		else $error("decimal remainder above clamp");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tdldc_pkg::ST_SCAN) |-> (32'(idx_q) < 32'(TABLE_ENTRIES)))
		else $error("scan index past last entry");

	a_tens_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tdldc_pkg::ST_FORM) |-> (tens_q <= 4'd9))
		else $error("tens digit out of range");
`endif

endmodule

`default_nettype wire
